### sv/hpt_pkg.sv
package hpt_pkg;

   localparam int CH_W         = 8;
   localparam int KIND_W       = 3;
   localparam int BYTE_W       = 8;
   localparam int ERR_W        = 4;
   localparam int BC_W         = 12;
   localparam int ACC_W        = 9;
   localparam int ALT_W        = 8;
   localparam int NIB_W        = 4;
   localparam int COUNT_BITS_DEF = 12;

   localparam logic [BC_W-1:0]   BC_MAX   = 12'hFFF;
   localparam logic [ACC_W-1:0]  ACC_SAT  = 9'd256;
   localparam logic [ALT_W-1:0]  ALT_MAX  = 8'hFF;
   localparam logic [BYTE_W-1:0] MASK_NIB = 8'h0F;
   localparam logic [BYTE_W-1:0] MASK_ALL = 8'hFF;
   localparam logic [BYTE_W-1:0] MAX_SKIP_RST = 8'hFF;

   localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEP   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RANGE = 3'd5;
   localparam logic [KIND_W-1:0] KIND_END   = 3'd6;

   localparam logic [ERR_W-1:0] ERR_NONE      = 4'd0;
   localparam logic [ERR_W-1:0] ERR_UNPAIRED  = 4'd1;
   localparam logic [ERR_W-1:0] ERR_NESTED    = 4'd2;
   localparam logic [ERR_W-1:0] ERR_SEP       = 4'd3;
   localparam logic [ERR_W-1:0] ERR_SKIP_ALT  = 4'd4;
   localparam logic [ERR_W-1:0] ERR_BRACKET   = 4'd5;
   localparam logic [ERR_W-1:0] ERR_SKIP_END  = 4'd6;
   localparam logic [ERR_W-1:0] ERR_SKIP_SKIP = 4'd7;
   localparam logic [ERR_W-1:0] ERR_SKIP_VAL  = 4'd8;
   localparam logic [ERR_W-1:0] ERR_CHAR      = 4'd9;
   localparam logic [ERR_W-1:0] ERR_FIRST     = 4'd10;
   localparam logic [ERR_W-1:0] ERR_ALT       = 4'd11;

   localparam logic [1:0] DASH_NONE = 2'd0;
   localparam logic [1:0] DASH_ONE  = 2'd1;
   localparam logic [1:0] DASH_TWO  = 2'd2;
   localparam logic [1:0] DASH_BAD  = 2'd3;

   localparam logic [4:0] PEND_NONE = 5'd0;
   localparam logic [4:0] PEND_WILD = 5'd1;

   localparam logic [CH_W-1:0] C_LPAR   = 8'h28;
   localparam logic [CH_W-1:0] C_RPAR   = 8'h29;
   localparam logic [CH_W-1:0] C_BAR    = 8'h7C;
   localparam logic [CH_W-1:0] C_LBRK   = 8'h5B;
   localparam logic [CH_W-1:0] C_RBRK   = 8'h5D;
   localparam logic [CH_W-1:0] C_DASH   = 8'h2D;

   typedef struct packed {
      logic [CH_W-1:0]  uc;
      logic             is_nib;
      logic             is_wild;
      logic             is_digit;
      logic [NIB_W-1:0] nib_val;
      logic             is_ws;
      logic             is_gz;
   } char_class_type;

endpackage

### sv/hpt_if.sv
interface hpt_req_if;
   logic                        valid;
   logic                        ready;
   logic [hpt_pkg::CH_W-1:0]    ch;
   logic                        last;
   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface hpt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hpt_pkg::KIND_W-1:0]   kind;
   logic [hpt_pkg::BYTE_W-1:0]   value;
   logic [hpt_pkg::BYTE_W-1:0]   mask;
   logic [hpt_pkg::BYTE_W-1:0]   skip_lo;
   logic [hpt_pkg::BYTE_W-1:0]   skip_hi;
   logic [hpt_pkg::ERR_W-1:0]    error;
   logic [hpt_pkg::BC_W-1:0]     byte_count;
   logic                         done_res;
   modport source (output valid, output kind, output value, output mask, output skip_lo,
                   output skip_hi, output error, output byte_count, output done_res,
                   input ready);
   modport sink   (input valid, input kind, input value, input mask, input skip_lo,
                   input skip_hi, input error, input byte_count, input done_res,
                   output ready);
endinterface

interface hpt_csr_if;
   logic                         valid;
   logic                         ready;
   logic [hpt_pkg::BYTE_W-1:0]   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/hpt_char_class.sv
module hpt_char_class (
   input  logic [hpt_pkg::CH_W-1:0] ch,
   output hpt_pkg::char_class_type  cls
);
   import hpt_pkg::*;

   logic [CH_W-1:0] uc;

   always_comb begin
      uc = ch;
      if (ch inside {[8'h61:8'h7A]}) begin
         uc = ch - 8'd32;
      end
      cls          = '0;
      cls.uc       = uc;
      cls.is_ws    = uc inside {8'h20, 8'h0A, 8'h09};
      cls.is_gz    = uc inside {[8'h47:8'h5A]};
      cls.is_digit = uc inside {[8'h30:8'h39]};
      if (uc inside {[8'h30:8'h39]}) begin
         cls.is_nib  = 1'b1;
         cls.nib_val = NIB_W'(uc - 8'h30);
      end else if (uc inside {[8'h41:8'h46]}) begin
         cls.is_nib  = 1'b1;
         cls.nib_val = NIB_W'(uc - 8'h37);
      end else if (uc == 8'h3F) begin
         cls.is_nib  = 1'b1;
         cls.is_wild = 1'b1;
      end
   end

endmodule

### sv/hex_pattern_tokenizer.sv
// Channel   Direction  Payload                                           Accepted when
// req_chan  in         ch, last                                          valid && ready
// rsp_chan  out        kind, value, mask, skip_lo, skip_hi, error,       valid && ready
//                      byte_count, done_res
// csr_chan  in         data (max_skip)                                   valid && ready
//
// One character per cycle when req is ready: decode and state update sit between
// the pattern state registers and the result register; a token shows in the cycle
// after its character. req ready drops only while a token waits and rsp is stalled.
// Synchronous reset clears the pattern state and sets max_skip to 255.
// csr ready is always high.
module hex_pattern_tokenizer #(
   parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   hpt_req_if.sink  req_chan,
   hpt_rsp_if.source rsp_chan,
   hpt_csr_if.sink  csr_chan
);
   import hpt_pkg::*;

   localparam int CW = (COUNT_BITS > BC_W) ? COUNT_BITS : BC_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   char_class_type cls;

   logic [BYTE_W-1:0]     max_skip_ff;
   logic                  started_ff, started_in;
   logic [4:0]            pend_ff, pend_in;
   logic                  in_alt_ff, in_alt_in;
   logic                  in_brk_ff, in_brk_in;
   logic [1:0]            dash_ff, dash_in;
   logic                  low_dig_ff, low_dig_in;
   logic [ACC_W-1:0]      low_ff, low_in;
   logic [ACC_W-1:0]      high_ff, high_in;
   logic                  after_skip_ff, after_skip_in;
   logic [ALT_W-1:0]      alt_cnt_ff, alt_cnt_in;
   logic                  prev_alt_ff, prev_alt_in;
   logic                  first_ff, first_in;
   logic [ERR_W-1:0]      err_ff, err_in;
   logic [COUNT_BITS-1:0] bytes_ff, bytes_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [BYTE_W-1:0]     value_ff, value_in;
   logic [BYTE_W-1:0]     mask_ff, mask_in;
   logic [BYTE_W-1:0]     lo_ff, lo_in;
   logic [BYTE_W-1:0]     hi_ff, hi_in;
   logic [ERR_W-1:0]      rerr_ff, rerr_in;
   logic [BC_W-1:0]       cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   logic                  req_acc;
   logic                  out_vld;
   logic                  em_req;
   logic [KIND_W-1:0]     em_kind;
   logic [BYTE_W-1:0]     em_val, em_mask, em_lo, em_hi;
   logic [CW-1:0]         cnt_ext;
   logic [11:0]           acc_tmp;
   logic                  emit_ok;

   hpt_char_class u_class (
      .ch  (req_chan.ch),
      .cls (cls)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign cnt_ext        = CW'(bytes_ff);

   always_comb begin
      started_in    = started_ff;
      pend_in       = pend_ff;
      in_alt_in     = in_alt_ff;
      in_brk_in     = in_brk_ff;
      dash_in       = dash_ff;
      low_dig_in    = low_dig_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      after_skip_in = after_skip_ff;
      alt_cnt_in    = alt_cnt_ff;
      prev_alt_in   = prev_alt_ff;
      first_in      = first_ff;
      err_in        = err_ff;
      bytes_in      = bytes_ff;
      out_vld = 1'b0;
      kind_in = '0; value_in = '0; mask_in = '0; lo_in = '0; hi_in = '0;
      rerr_in = '0; cnt_in = '0; done_in = 1'b0;
      em_req = 1'b0; em_kind = KIND_BYTE;
      em_val = '0; em_mask = '0; em_lo = '0; em_hi = '0;
      acc_tmp = '0;
      emit_ok = 1'b1;

      if (req_chan.last) begin
         rerr_in = err_ff;
         if (rerr_in == ERR_NONE && pend_ff != PEND_NONE) rerr_in = ERR_UNPAIRED;
         if (rerr_in == ERR_NONE && in_brk_ff) rerr_in = ERR_BRACKET;
         if (rerr_in == ERR_NONE && after_skip_ff) rerr_in = ERR_SKIP_END;
         if (rerr_in == ERR_NONE && in_alt_ff) rerr_in = ERR_ALT;
         if (rerr_in == ERR_NONE && !first_ff) rerr_in = ERR_FIRST;
         out_vld = 1'b1;
         kind_in = KIND_END;
         done_in = 1'b1;
         cnt_in  = (cnt_ext > CW'(BC_MAX)) ? BC_MAX : cnt_ext[BC_W-1:0];
         started_in = 1'b0; pend_in = PEND_NONE; in_alt_in = 1'b0; in_brk_in = 1'b0;
         dash_in = DASH_NONE; low_dig_in = 1'b0; low_in = '0; high_in = '0;
         after_skip_in = 1'b0; alt_cnt_in = '0; prev_alt_in = 1'b0; first_in = 1'b0;
         err_in = ERR_NONE; bytes_in = '0;
      end else if (err_ff != ERR_NONE) begin
         // error latched: swallow until end
      end else if (!started_ff) begin
         started_in = 1'b1;
      end else if (in_brk_ff) begin
         if (cls.uc == C_RBRK) begin
            in_brk_in = 1'b0;
            if (dash_ff == DASH_BAD || low_ff > ACC_W'(max_skip_ff)) begin
               err_in = ERR_SKIP_VAL;
            end else if (dash_ff != DASH_NONE) begin
               if (high_ff <= low_ff || high_ff > ACC_W'(max_skip_ff)) begin
                  err_in = ERR_SKIP_VAL;
               end else begin
                  after_skip_in = 1'b1;
                  em_req  = 1'b1;
                  em_kind = KIND_RANGE;
                  em_lo   = low_ff[BYTE_W-1:0];
                  em_hi   = high_ff[BYTE_W-1:0];
               end
            end else begin
               after_skip_in = 1'b1;
               em_req  = 1'b1;
               em_kind = KIND_SKIP;
               em_lo   = low_ff[BYTE_W-1:0];
            end
         end else if (dash_ff == DASH_BAD) begin
            // malformed, wait for close
         end else if (cls.is_digit) begin
            if (dash_ff == DASH_NONE) begin
               acc_tmp    = 12'(low_ff) * 12'd10 + 12'(cls.nib_val);
               low_in     = (acc_tmp > 12'(ACC_SAT)) ? ACC_SAT : acc_tmp[ACC_W-1:0];
               low_dig_in = 1'b1;
            end else if (dash_ff == DASH_ONE) begin
               acc_tmp = 12'(high_ff) * 12'd10 + 12'(cls.nib_val);
               high_in = (acc_tmp > 12'(ACC_SAT)) ? ACC_SAT : acc_tmp[ACC_W-1:0];
            end
         end else if (cls.uc == C_DASH) begin
            if (dash_ff == DASH_NONE) begin
               dash_in = low_dig_ff ? DASH_ONE : DASH_BAD;
            end else if (dash_ff == DASH_ONE) begin
               dash_in = DASH_TWO;
            end
         end else begin
            dash_in = DASH_BAD;
         end
      end else if (after_skip_ff && !cls.is_ws && cls.uc == C_LBRK) begin
         err_in = ERR_SKIP_SKIP;
      end else begin
         if (after_skip_ff && !cls.is_ws) begin
            after_skip_in = 1'b0;
         end
         if (pend_ff != PEND_NONE) begin
            if (!cls.is_nib) begin
               err_in = cls.is_gz ? ERR_CHAR : ERR_UNPAIRED;
            end else begin
               pend_in = PEND_NONE;
               em_req  = 1'b1;
               em_kind = KIND_BYTE;
               em_val  = {(pend_ff == PEND_WILD) ? 4'h0 : pend_ff[3:0],
                          cls.is_wild ? 4'h0 : cls.nib_val};
               em_mask = {(pend_ff == PEND_WILD) ? 4'h0 : MASK_NIB[3:0],
                          cls.is_wild ? 4'h0 : MASK_NIB[3:0]};
            end
         end else if (cls.is_nib) begin
            pend_in = cls.is_wild ? PEND_WILD : {1'b1, cls.nib_val};
         end else if (cls.uc == C_LPAR) begin
            if (in_alt_ff) begin
               err_in = ERR_NESTED;
            end else begin
               in_alt_in = 1'b1;
               em_req    = 1'b1;
               em_kind   = KIND_OPEN;
            end
         end else if (cls.uc == C_RPAR) begin
            in_alt_in = 1'b0;
            em_req    = 1'b1;
            em_kind   = KIND_CLOSE;
         end else if (cls.uc == C_BAR) begin
            if (!in_alt_ff) begin
               err_in = ERR_SEP;
            end else begin
               em_req  = 1'b1;
               em_kind = KIND_SEP;
            end
         end else if (cls.uc == C_LBRK) begin
            if (in_alt_ff) begin
               err_in = ERR_SKIP_ALT;
            end else begin
               in_brk_in  = 1'b1;
               dash_in    = DASH_NONE;
               low_dig_in = 1'b0;
               low_in     = '0;
               high_in    = '0;
            end
         end else if (cls.uc == C_RBRK) begin
            err_in = ERR_BRACKET;
         end else if (!cls.is_ws) begin
            err_in = ERR_CHAR;
         end
      end

      // token checks: first token, alternation syntax, byte count
      if (em_req) begin
         if (!first_ff) begin
            first_in = 1'b1;
            if (em_kind != KIND_BYTE || em_mask != MASK_ALL) begin
               err_in  = ERR_FIRST;
               emit_ok = 1'b0;
            end
         end
         if (emit_ok) begin
            if (em_kind == KIND_OPEN || em_kind == KIND_SEP) begin
               if (prev_alt_ff && em_kind == KIND_SEP) begin
                  err_in  = ERR_ALT;
                  emit_ok = 1'b0;
               end else begin
                  if (alt_cnt_ff != ALT_MAX) alt_cnt_in = alt_cnt_ff + 1'b1;
                  prev_alt_in = 1'b1;
               end
            end else if (em_kind == KIND_CLOSE) begin
               if (prev_alt_ff || alt_cnt_ff < ALT_W'(2)) begin
                  err_in  = ERR_ALT;
                  emit_ok = 1'b0;
               end else begin
                  alt_cnt_in  = '0;
                  prev_alt_in = 1'b0;
               end
            end else begin
               prev_alt_in = 1'b0;
            end
         end
         if (emit_ok) begin
            if (em_kind == KIND_BYTE && bytes_ff != CNT_MAX) bytes_in = bytes_ff + 1'b1;
            out_vld  = 1'b1;
            kind_in  = em_kind;
            value_in = em_val;
            mask_in  = em_mask;
            lo_in    = em_lo;
            hi_in    = em_hi;
         end
      end

      if (req_acc && out_vld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_skip_ff   <= MAX_SKIP_RST;
         started_ff    <= 1'b0;
         pend_ff       <= PEND_NONE;
         in_alt_ff     <= 1'b0;
         in_brk_ff     <= 1'b0;
         dash_ff       <= DASH_NONE;
         low_dig_ff    <= 1'b0;
         low_ff        <= '0;
         high_ff       <= '0;
         after_skip_ff <= 1'b0;
         alt_cnt_ff    <= '0;
         prev_alt_ff   <= 1'b0;
         first_ff      <= 1'b0;
         err_ff        <= ERR_NONE;
         bytes_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            max_skip_ff <= csr_chan.data;
         end
         if (req_acc) begin
            started_ff    <= started_in;
            pend_ff       <= pend_in;
            in_alt_ff     <= in_alt_in;
            in_brk_ff     <= in_brk_in;
            dash_ff       <= dash_in;
            low_dig_ff    <= low_dig_in;
            low_ff        <= low_in;
            high_ff       <= high_in;
            after_skip_ff <= after_skip_in;
            alt_cnt_ff    <= alt_cnt_in;
            prev_alt_ff   <= prev_alt_in;
            first_ff      <= first_in;
            err_ff        <= err_in;
            bytes_ff      <= bytes_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && out_vld) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         mask_ff  <= mask_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         rerr_ff  <= rerr_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = kind_ff;
   assign rsp_chan.value      = value_ff;
   assign rsp_chan.mask       = mask_ff;
   assign rsp_chan.skip_lo    = lo_ff;
   assign rsp_chan.skip_hi    = hi_ff;
   assign rsp_chan.error      = rerr_ff;
   assign rsp_chan.byte_count = cnt_ff;
   assign rsp_chan.done_res   = done_ff;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hpt_pkg::*;

   localparam int PLAN_LEN    = 29;
   localparam int PHASE_ITEMS = 100;
   localparam int STALL_LEN   = 48;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYC  = 4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] mask;
      logic [BYTE_W-1:0] skip_lo;
      logic [BYTE_W-1:0] skip_hi;
      logic [ERR_W-1:0]  error;
      logic [BC_W-1:0]   byte_count;
      logic              done_res;
   } token_type;

   typedef enum bit {ROW_MODEL, ROW_TYPED} row_mode_type;

   typedef struct {
      logic [CH_W-1:0] ch;
      logic            last;
      row_mode_type    mode;
      token_type       tok;
   } plan_row_type;

   localparam token_type NO_TOK = '0;

   logic clock;
   logic reset;

   hpt_req_if req();
   hpt_rsp_if rsp();
   hpt_csr_if csr();

   hex_pattern_tokenizer uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   plan_row_type plan [PLAN_LEN] = '{
      '{"{", 1'b0, ROW_MODEL, NO_TOK},
      '{"a", 1'b0, ROW_MODEL, NO_TOK},
      '{"B", 1'b0, ROW_TYPED, '{KIND_BYTE, 8'hAB, 8'hFF, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{"(", 1'b0, ROW_TYPED, '{KIND_OPEN, 8'h0, 8'h0, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{"?", 1'b0, ROW_MODEL, NO_TOK},
      '{"7", 1'b0, ROW_TYPED, '{KIND_BYTE, 8'h07, 8'h0F, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{"|", 1'b0, ROW_TYPED, '{KIND_SEP, 8'h0, 8'h0, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{"e", 1'b0, ROW_MODEL, NO_TOK},
      '{"?", 1'b0, ROW_TYPED, '{KIND_BYTE, 8'hE0, 8'hF0, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{")", 1'b0, ROW_TYPED, '{KIND_CLOSE, 8'h0, 8'h0, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{"[", 1'b0, ROW_MODEL, NO_TOK},
      '{"2", 1'b0, ROW_MODEL, NO_TOK},
      '{"-", 1'b0, ROW_MODEL, NO_TOK},
      '{"9", 1'b0, ROW_MODEL, NO_TOK},
      '{"]", 1'b0, ROW_TYPED, '{KIND_RANGE, 8'h0, 8'h0, 8'd2, 8'd9, ERR_NONE, 12'd0, 1'b0}},
      '{"?", 1'b0, ROW_MODEL, NO_TOK},
      '{"?", 1'b0, ROW_MODEL, NO_TOK},
      '{"[", 1'b0, ROW_MODEL, NO_TOK},
      '{"]", 1'b0, ROW_TYPED, '{KIND_SKIP, 8'h0, 8'h0, 8'd0, 8'd0, ERR_NONE, 12'd0, 1'b0}},
      '{"f", 1'b0, ROW_MODEL, NO_TOK},
      '{"F", 1'b0, ROW_TYPED, '{KIND_BYTE, 8'hFF, 8'hFF, 8'h0, 8'h0, ERR_NONE, 12'd0, 1'b0}},
      '{"}", 1'b1, ROW_TYPED, '{KIND_END, 8'h0, 8'h0, 8'h0, 8'h0, ERR_NONE, 12'd5, 1'b1}},
      '{8'hFF, 1'b0, ROW_MODEL, NO_TOK},
      '{"G", 1'b0, ROW_MODEL, NO_TOK},
      '{8'h00, 1'b1, ROW_TYPED, '{KIND_END, 8'h0, 8'h0, 8'h0, 8'h0, ERR_CHAR, 12'd0, 1'b1}},
      '{"}", 1'b1, ROW_TYPED, '{KIND_END, 8'h0, 8'h0, 8'h0, 8'h0, ERR_FIRST, 12'd0, 1'b1}},
      '{8'h80, 1'b0, ROW_MODEL, NO_TOK},
      '{"(", 1'b0, ROW_MODEL, NO_TOK},
      '{8'h7F, 1'b1, ROW_TYPED, '{KIND_END, 8'h0, 8'h0, 8'h0, 8'h0, ERR_FIRST, 12'd0, 1'b1}}
   };

   // tokenizer state as predicted
   logic [BYTE_W-1:0] max_skip_q;
   logic              pat_started;
   logic [4:0]        pend_nib;
   logic              in_alt;
   logic              in_brk;
   logic [1:0]        dash_st;
   logic              lo_seen;
   logic [ACC_W-1:0]  lo_acc;
   logic [ACC_W-1:0]  hi_acc;
   logic              post_skip;
   logic [ALT_W-1:0]  alt_cnt;
   logic              prev_marker;
   logic              first_seen;
   logic [ERR_W-1:0]  err_code;
   logic [BC_W-1:0]   byte_cnt;

   token_type       tokens_due[$];
   logic [CH_W-1:0] pat_chars[$];
   int              items_sent;
   int              mismatches;
   bit              no_idle;
   int              stall_asked;
   int              stall_seen;
   int              stall_left;
   int              quiet;
   token_type       seen_tok;
   token_type       want_tok;

   function automatic void pat_clear();
      pat_started = 1'b0;
      pend_nib    = PEND_NONE;
      in_alt      = 1'b0;
      in_brk      = 1'b0;
      dash_st     = DASH_NONE;
      lo_seen     = 1'b0;
      lo_acc      = '0;
      hi_acc      = '0;
      post_skip   = 1'b0;
      alt_cnt     = '0;
      prev_marker = 1'b0;
      first_seen  = 1'b0;
      err_code    = ERR_NONE;
      byte_cnt    = '0;
   endfunction

   function automatic void note_err(input logic [ERR_W-1:0] code);
      if (err_code == ERR_NONE) err_code = code;
   endfunction

   function automatic int nib_of(input logic [CH_W-1:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c == "?") return 16;
      return -1;
   endfunction

   function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [CH_W-1:0] d);
      int v;
      v = acc * 10 + d;
      return (v > ACC_SAT) ? ACC_SAT : v[ACC_W-1:0];
   endfunction

   function automatic bit emit_tok(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] v,
                                   input logic [BYTE_W-1:0] m, input logic [BYTE_W-1:0] lo,
                                   input logic [BYTE_W-1:0] hi, output token_type t);
      t = '0;
      if (!first_seen) begin
         first_seen = 1'b1;
         if (k != KIND_BYTE || m != MASK_ALL) begin
            note_err(ERR_FIRST);
            return 1'b0;
         end
      end
      if (k == KIND_OPEN || k == KIND_SEP) begin
         if (prev_marker && k == KIND_SEP) begin
            note_err(ERR_ALT);
            return 1'b0;
         end
         if (alt_cnt < ALT_MAX) alt_cnt++;
         prev_marker = 1'b1;
      end else if (k == KIND_CLOSE) begin
         if (prev_marker || alt_cnt < 2) begin
            note_err(ERR_ALT);
            return 1'b0;
         end
         alt_cnt     = '0;
         prev_marker = 1'b0;
      end else begin
         prev_marker = 1'b0;
      end
      if (k == KIND_BYTE && byte_cnt < BC_MAX) byte_cnt++;
      t.kind    = k;
      t.value   = v;
      t.mask    = m;
      t.skip_lo = lo;
      t.skip_hi = hi;
      return 1'b1;
   endfunction

   function automatic bit brk_close(output token_type t);
      t      = '0;
      in_brk = 1'b0;
      if (dash_st == DASH_BAD || lo_acc > max_skip_q) begin
         note_err(ERR_SKIP_VAL);
         return 1'b0;
      end
      if (dash_st != DASH_NONE) begin
         if (hi_acc <= lo_acc || hi_acc > max_skip_q) begin
            note_err(ERR_SKIP_VAL);
            return 1'b0;
         end
         post_skip = 1'b1;
         return emit_tok(KIND_RANGE, '0, '0, lo_acc[7:0], hi_acc[7:0], t);
      end
      post_skip = 1'b1;
      return emit_tok(KIND_SKIP, '0, '0, lo_acc[7:0], '0, t);
   endfunction

   function automatic bit brk_char(input logic [CH_W-1:0] c, output token_type t);
      t = '0;
      if (c == C_RBRK) return brk_close(t);
      if (dash_st == DASH_BAD) return 1'b0;
      if (c >= "0" && c <= "9") begin
         if (dash_st == DASH_NONE) begin
            lo_acc  = acc_digit(lo_acc, c - "0");
            lo_seen = 1'b1;
         end else if (dash_st == DASH_ONE) begin
            hi_acc = acc_digit(hi_acc, c - "0");
         end
      end else if (c == C_DASH) begin
         if (dash_st == DASH_NONE) dash_st = lo_seen ? DASH_ONE : DASH_BAD;
         else if (dash_st == DASH_ONE) dash_st = DASH_TWO;
      end else begin
         dash_st = DASH_BAD;
      end
      return 1'b0;
   endfunction

   function automatic bit tokenize(input logic [CH_W-1:0] ch_in, input logic last_in,
                                   output token_type t);
      logic [CH_W-1:0] c;
      bit              ws;
      int              n;
      logic [3:0]      hv, hm, lv, lm;
      t = '0;
      c = ch_in;
      if (last_in) begin
         if (pend_nib != PEND_NONE) note_err(ERR_UNPAIRED);
         if (in_brk) note_err(ERR_BRACKET);
         if (post_skip) note_err(ERR_SKIP_END);
         if (in_alt) note_err(ERR_ALT);
         if (!first_seen) note_err(ERR_FIRST);
         t.kind       = KIND_END;
         t.error      = err_code;
         t.byte_count = byte_cnt;
         t.done_res   = 1'b1;
         pat_clear();
         return 1'b1;
      end
      if (err_code != ERR_NONE) return 1'b0;
      if (!pat_started) begin
         pat_started = 1'b1;
         return 1'b0;
      end
      if (c >= "a" && c <= "z") c = c - 8'd32;
      if (in_brk) return brk_char(c, t);

      ws = (c == " " || c == 8'h0A || c == 8'h09);
      if (post_skip && !ws) begin
         if (c == C_LBRK) begin
            note_err(ERR_SKIP_SKIP);
            return 1'b0;
         end
         post_skip = 1'b0;
      end

      n = nib_of(c);
      if (pend_nib != PEND_NONE) begin
         if (n < 0) begin
            note_err((c >= "G" && c <= "Z") ? ERR_CHAR : ERR_UNPAIRED);
            return 1'b0;
         end
         hv = (pend_nib == PEND_WILD) ? 4'h0 : pend_nib[3:0];
         hm = (pend_nib == PEND_WILD) ? 4'h0 : 4'hF;
         lv = (n == 16) ? 4'h0 : n[3:0];
         lm = (n == 16) ? 4'h0 : 4'hF;
         pend_nib = PEND_NONE;
         return emit_tok(KIND_BYTE, {hv, lv}, {hm, lm}, '0, '0, t);
      end
      if (n >= 0) begin
         pend_nib = (n == 16) ? PEND_WILD : {1'b1, n[3:0]};
         return 1'b0;
      end
      if (c == C_LPAR) begin
         if (in_alt) begin
            note_err(ERR_NESTED);
            return 1'b0;
         end
         in_alt = 1'b1;
         return emit_tok(KIND_OPEN, '0, '0, '0, '0, t);
      end
      if (c == C_RPAR) begin
         in_alt = 1'b0;
         return emit_tok(KIND_CLOSE, '0, '0, '0, '0, t);
      end
      if (c == C_BAR) begin
         if (!in_alt) begin
            note_err(ERR_SEP);
            return 1'b0;
         end
         return emit_tok(KIND_SEP, '0, '0, '0, '0, t);
      end
      if (c == C_LBRK) begin
         if (in_alt) begin
            note_err(ERR_SKIP_ALT);
            return 1'b0;
         end
         in_brk  = 1'b1;
         dash_st = DASH_NONE;
         lo_seen = 1'b0;
         lo_acc  = '0;
         hi_acc  = '0;
         return 1'b0;
      end
      if (c == C_RBRK) begin
         note_err(ERR_BRACKET);
         return 1'b0;
      end
      if (ws) return 1'b0;
      note_err(ERR_CHAR);
      return 1'b0;
   endfunction

   // pattern generation
   function automatic logic [CH_W-1:0] nib_char(input bit wild_ok);
      int r;
      r = $urandom_range(0, 26);
      if (wild_ok && r >= 22) return "?";
      r = r % 22;
      if (r < 10) return CH_W'("0" + r);
      if (r < 16) return CH_W'("A" + r - 10);
      return CH_W'("a" + r - 16);
   endfunction

   function automatic void push_byte(input bit full);
      pat_chars.push_back(nib_char(!full));
      pat_chars.push_back(nib_char(!full));
   endfunction

   function automatic void push_space();
      case ($urandom_range(0, 2))
         0:       pat_chars.push_back(" ");
         1:       pat_chars.push_back(8'h0A);
         default: pat_chars.push_back(8'h09);
      endcase
   endfunction

   function automatic void push_num(input int v);
      string s;
      int    k;
      s = $sformatf("%0d", v);
      for (k = 0; k < s.len(); k++) pat_chars.push_back(s[k]);
   endfunction

   function automatic void push_skip();
      int lo, hi;
      lo = $urandom_range(0, max_skip_q);
      hi = lo + $urandom_range(1, 20);
      pat_chars.push_back(C_LBRK);
      case ($urandom_range(0, 11))
         0, 1, 2, 3: push_num(lo);
         4, 5, 6, 7: begin
            push_num(lo);
            pat_chars.push_back(C_DASH);
            push_num(hi);
         end
         8:  ;
         9:  push_num($urandom_range(256, 99999));
         10: begin
            pat_chars.push_back(C_DASH);
            push_num(hi);
         end
         default: begin
            push_num(lo);
            pat_chars.push_back(C_DASH);
            if ($urandom_range(0, 1)) begin
               push_num(hi);
               pat_chars.push_back(C_DASH);
               push_num($urandom_range(0, 300));
            end
         end
      endcase
      pat_chars.push_back(C_RBRK);
   endfunction

   function automatic logic [CH_W-1:0] noise_char();
      case ($urandom_range(0, 9))
         0:       return C_LPAR;
         1:       return C_RPAR;
         2:       return C_BAR;
         3:       return C_LBRK;
         4:       return C_RBRK;
         5:       return C_DASH;
         6:       return "g";
         7:       return "Z";
         8:       return " ";
         default: return "?";
      endcase
   endfunction

   function automatic void corrupt();
      int              at;
      logic [CH_W-1:0] junk;
      at   = $urandom_range(1, pat_chars.size());
      junk = $urandom_range(0, 1) ? CH_W'($urandom_range(0, 255)) : noise_char();
      case ($urandom_range(0, 2))
         0: pat_chars.insert(at, junk);
         1: begin
            if (at < pat_chars.size()) pat_chars[at] = junk;
            else pat_chars.push_back(junk);
         end
         default: begin
            if (at < pat_chars.size()) pat_chars.delete(at);
         end
      endcase
   endfunction

   function automatic void gen_pattern();
      int elems, e, j, alts;
      pat_chars.delete();
      pat_chars.push_back(CH_W'($urandom_range(0, 255)));
      push_byte($urandom_range(0, 9) != 0);
      elems = $urandom_range(1, 8);
      for (e = 0; e < elems; e++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_byte(1'b0);
            4, 5: begin
               pat_chars.push_back(C_LPAR);
               alts = $urandom_range(2, 3);
               for (j = 0; j < alts; j++) begin
                  if (j != 0) pat_chars.push_back(C_BAR);
                  repeat ($urandom_range(1, 2)) push_byte(1'b0);
               end
               pat_chars.push_back(C_RPAR);
            end
            6, 7: begin
               push_skip();
               if ($urandom_range(0, 3) == 0) push_space();
               if ($urandom_range(0, 5) != 0) push_byte(1'b0);
            end
            default: push_space();
         endcase
      end
      if ($urandom_range(0, 2) == 0) begin
         corrupt();
         if ($urandom_range(0, 2) == 0) corrupt();
      end
   endfunction

   // driving
   task automatic offer(input logic [CH_W-1:0] c, input logic l);
      while (!no_idle && $urandom_range(0, 99) < 30) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.ch    <= c;
      req.last  <= l;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic feed(input logic [CH_W-1:0] c, input logic l);
      token_type t;
      offer(c, l);
      if (tokenize(c, l, t)) tokens_due.push_back(t);
      items_sent++;
   endtask

   task automatic send_pattern();
      int k, sel;
      sel = $urandom_range(0, 24);
      if (sel == 1) begin
         feed(CH_W'($urandom_range(0, 255)), 1'b0);
      end else if (sel != 0) begin
         gen_pattern();
         for (k = 0; k < pat_chars.size(); k++) feed(pat_chars[k], 1'b0);
      end
      feed(CH_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_max_skip(input logic [BYTE_W-1:0] v);
      csr.valid <= 1'b1;
      csr.data  <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      max_skip_q = v;
      csr.valid <= 1'b0;
   endtask

   task automatic report(input string what, input token_type want, input token_type got);
      if (mismatches < 10) begin
         $display("%s want: kind %0d val %h mask %h lo %0d hi %0d err %0d cnt %0d done %b",
                  what, want.kind, want.value, want.mask, want.skip_lo, want.skip_hi,
                  want.error, want.byte_count, want.done_res);
         $display("%s  got: kind %0d val %h mask %h lo %0d hi %0d err %0d cnt %0d done %b",
                  what, got.kind, got.value, got.mask, got.skip_lo, got.skip_hi,
                  got.error, got.byte_count, got.done_res);
      end
      mismatches++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random stalls plus one long hold-off on request
   initial begin
      rsp.ready <= 1'b0;
      stall_seen = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else if (stall_seen != stall_asked) begin
            stall_seen = stall_asked;
            stall_left = STALL_LEN - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= no_idle || ($urandom_range(0, 99) >= 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         seen_tok = '{rsp.kind, rsp.value, rsp.mask, rsp.skip_lo, rsp.skip_hi,
                      rsp.error, rsp.byte_count, rsp.done_res};
         if (tokens_due.size() == 0) begin
            report("unexpected transaction", NO_TOK, seen_tok);
         end else begin
            want_tok = tokens_due.pop_front();
            if (seen_tok !== want_tok) report("token mismatch", want_tok, seen_tok);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("hex_pattern_tokenizer test failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int              i, ph;
      token_type       tok;
      bit              has;
      logic [BYTE_W-1:0] cfg;
      reset     <= 1'b1;
      req.valid <= 1'b0;
      req.ch    <= '0;
      req.last  <= 1'b0;
      csr.valid <= 1'b0;
      csr.data  <= '0;
      mismatches  = 0;
      items_sent  = 0;
      no_idle     = 1'b0;
      stall_asked = 0;
      max_skip_q  = MAX_SKIP_RST;
      pat_clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_LEN; i++) begin
         offer(plan[i].ch, plan[i].last);
         has = tokenize(plan[i].ch, plan[i].last, tok);
         if (plan[i].mode == ROW_TYPED) tokens_due.push_back(plan[i].tok);
         else if (has) tokens_due.push_back(tok);
         items_sent++;
      end
      settle();

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       cfg = '0;
            1:       cfg = BYTE_W'($urandom_range(1, 20));
            2:       cfg = MAX_SKIP_RST;
            default: cfg = BYTE_W'($urandom_range(21, 254));
         endcase
         write_max_skip(cfg);
         no_idle = (ph == 2);
         if (ph == 1) stall_asked++;
         while (items_sent < PLAN_LEN + (ph + 1) * PHASE_ITEMS) send_pattern();
         settle();
      end

      if (mismatches == 0 && tokens_due.size() == 0) begin
         $display("hex_pattern_tokenizer test passed");
      end else begin
         $display("hex_pattern_tokenizer test failed");
      end
      $finish;
   end

endmodule

### hex_pattern_tokenizer.f
sv/hpt_pkg.sv
sv/hpt_if.sv
sv/hpt_char_class.sv
sv/hex_pattern_tokenizer.sv
dv/tb_top.sv
